// ----- sv/joystick_servo_position_stepper_core_defines.svh -----
// ----------------------------------------------------------------------------
// Joystick servo stepper assertion macros
// Shared concurrent assertion forms, clocked on clk_i, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef JOYSTICK_SERVO_POSITION_STEPPER_CORE_DEFINES_SVH
`define JOYSTICK_SERVO_POSITION_STEPPER_CORE_DEFINES_SVH

// same-cycle implication
`define JSPS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("jsps assertion failed");

// next-cycle implication
`define JSPS_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("jsps assertion failed");

`endif

// ----- sv/jsps_pkg.sv -----
// ----------------------------------------------------------------------------
// jsps_pkg
// Types, constants and helper functions of the joystick servo stepper.
// ----------------------------------------------------------------------------
package jsps_pkg;

  localparam int NumServos  = 4;
  localparam int QueueDepth = 2;

  typedef logic signed [4:0] step_t;   // -8 .. +8
  typedef logic [7:0]        angle_t;
  typedef logic [1:0]        chan_t;
  typedef logic [9:0]        pulse_t;

  // one classified report: which servos move and by how much
  typedef struct packed {
    logic [NumServos-1:0]  mask;
    step_t [NumServos-1:0] steps;
  } cmd_t;

  // dead zone
  localparam logic [15:0] DzLow     = 16'h7000;
  localparam logic [15:0] DzHigh    = 16'h8fff;
  localparam logic [15:0] CentreNeg = 16'h8000;
  localparam logic [15:0] CentrePos = 16'h7fff;

  // button bits
  localparam int BtnClose = 6;
  localparam int BtnOpen  = 7;

  localparam step_t GripStep = 5'sd5;

  // servo channels
  localparam chan_t ChBase  = 2'd0;
  localparam chan_t ChReach = 2'd1;
  localparam chan_t ChLift  = 2'd2;
  localparam chan_t ChGrip  = 2'd3;

  // config index: bit 0 picks min or max, upper bits pick the servo
  localparam logic CfgLimMax = 1'b1;

  localparam angle_t AngleReset = 8'd90;
  localparam angle_t MinReset [NumServos] = '{8'd20, 8'd70, 8'd45, 8'd70};
  localparam angle_t MaxReset [NumServos] = '{8'd160, 8'd110, 8'd135, 8'd110};

  // pulse = floor(411*a/180) + 101; 1/180 via reciprocal ceil(2^24/180) folded with 411
  localparam logic [25:0] PulseRecip = 26'd38308077;
  localparam int          PulseShift = 24;
  localparam pulse_t      PulseMin   = 10'd101;

  function automatic step_t axis_step(logic [15:0] v);
    logic [15:0] d;
    step_t       s;
    d = '0;
    s = '0;
    if (v <= DzLow) begin
      d = CentreNeg - v;
      s = -$signed({1'b0, d[15:12]});
    end else if (v >= DzHigh) begin
      d = v - CentrePos;
      s = $signed({1'b0, d[15:12]});
    end
    return s;
  endfunction

  function automatic pulse_t pulse_of(angle_t a);
    logic [33:0] p;
    p = {26'd0, a} * {8'd0, PulseRecip};
    return p[PulseShift+9:PulseShift] + PulseMin;
  endfunction

endpackage

// ----- sv/jsps_front.sv -----
// ----------------------------------------------------------------------------
// jsps_front
// Takes reports, turns stick axes and buttons into per-servo steps.
// ----------------------------------------------------------------------------
module jsps_front import jsps_pkg::*; (
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] left_x_i,
  input  logic [15:0] left_y_i,
  input  logic [15:0] right_y_i,
  input  logic [7:0]  button_bits_i,
  input  logic        full_i,
  output logic        push_o,
  output cmd_t        cmd_o
);

  step_t grip_step;

  always_comb begin
    grip_step = '0;
    if (button_bits_i[BtnClose]) begin
      grip_step = -GripStep;
    end else if (button_bits_i[BtnOpen]) begin
      grip_step = GripStep;
    end
  end

  always_comb begin
    cmd_o.steps[ChBase]  = axis_step(left_x_i);
    cmd_o.steps[ChReach] = -axis_step(left_y_i);
    cmd_o.steps[ChLift]  = -axis_step(right_y_i);
    cmd_o.steps[ChGrip]  = grip_step;
    for (int i = 0; i < NumServos; i++) begin
      cmd_o.mask[i] = (cmd_o.steps[i] != '0);
    end
  end

  assign in_ready_o = !full_i;
  // reports that move nothing are consumed here
  assign push_o     = in_valid_i && !full_i && (|cmd_o.mask);

endmodule

// ----- sv/jsps_fifo.sv -----
// ----------------------------------------------------------------------------
// jsps_fifo
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
module jsps_fifo import jsps_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  input  logic pop_i,
  output cmd_t head_o,
  output logic head_valid_o
);

  localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int CntW = $clog2(QueueDepth + 1);

  cmd_t            mem_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o       = (cnt_q == CntW'(QueueDepth));
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

// ----- sv/jsps_back.sv -----
// ----------------------------------------------------------------------------
// jsps_back
// Walks the moved servos of each command, clamps targets, drives results.
// ----------------------------------------------------------------------------
`include "joystick_servo_position_stepper_core_defines.svh"

module jsps_back import jsps_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cmd_t       head_i,
  input  logic       head_valid_i,
  output logic       pop_o,
  input  logic       cfg_valid_i,
  input  logic [2:0] cfg_index_i,
  input  logic [7:0] cfg_data_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output chan_t      servo_channel_o,
  output angle_t     servo_angle_o,
  output pulse_t     pulse_count_o,
  output logic       last_of_run_o
);

  angle_t                min_q [NumServos];
  angle_t                max_q [NumServos];
  angle_t                tgt_q [NumServos];
  logic [NumServos-1:0]  mask_q;
  step_t [NumServos-1:0] steps_q;

  logic   out_valid_q;
  chan_t  out_ch_q;
  angle_t out_ang_q;
  logic   out_last_q;

  logic                  busy, adv, fire, found;
  logic [NumServos-1:0]  work_mask, rem_mask;
  step_t [NumServos-1:0] work_steps;
  chan_t                 ch;
  logic signed [9:0]     sum, lo, hi, clamped;
  angle_t                ang_d;

  assign busy       = |mask_q;
  assign work_mask  = busy ? mask_q : (head_valid_i ? head_i.mask : '0);
  assign work_steps = busy ? steps_q : head_i.steps;
  assign adv        = !out_valid_q || out_ready_i;
  assign fire       = adv && (|work_mask);
  assign pop_o      = fire && !busy;

  // lowest pending servo goes first
  always_comb begin
    ch    = ChBase;
    found = 1'b0;
    for (int i = 0; i < NumServos; i++) begin
      if (work_mask[i] && !found) begin
        ch    = chan_t'(i);
        found = 1'b1;
      end
    end
  end

  assign rem_mask = work_mask & ~(NumServos'(1) << ch);

  // raise to min, then cap at max: max wins on crossed limits
  always_comb begin
    sum = $signed({2'b00, tgt_q[ch]}) + 10'(work_steps[ch]);
    lo  = $signed({2'b00, min_q[ch]});
    hi  = $signed({2'b00, max_q[ch]});
    clamped = sum;
    if (clamped < lo) begin
      clamped = lo;
    end
    if (clamped > hi) begin
      clamped = hi;
    end
    ang_d = clamped[7:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q      <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NumServos; i++) begin
        tgt_q[i] <= AngleReset;
        min_q[i] <= MinReset[i];
        max_q[i] <= MaxReset[i];
      end
    end else begin
      if (cfg_valid_i) begin
        if (cfg_index_i[0] == CfgLimMax) begin
          max_q[cfg_index_i[2:1]] <= cfg_data_i;
        end else begin
          min_q[cfg_index_i[2:1]] <= cfg_data_i;
        end
      end
      if (fire) begin
        tgt_q[ch]   <= ang_d;
        mask_q      <= rem_mask;
        out_valid_q <= 1'b1;
      end else if (adv) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      steps_q    <= work_steps;
      out_ch_q   <= ch;
      out_ang_q  <= ang_d;
      out_last_q <= (rem_mask == '0);
    end
  end

  assign out_valid_o     = out_valid_q;
  assign servo_channel_o = out_ch_q;
  assign servo_angle_o   = out_ang_q;
  assign pulse_count_o   = pulse_of(out_ang_q);
  assign last_of_run_o   = out_last_q;

  `JSPS_ASSERT_NOW(a_pop_only_idle, pop_o, mask_q == '0 && head_valid_i)
  `JSPS_ASSERT_NXT(a_last_clears, fire && rem_mask == '0, mask_q == '0 && out_last_q)
  `JSPS_ASSERT_NOW(a_angle_in_lim,
    out_valid_q && (min_q[out_ch_q] <= max_q[out_ch_q]),
    out_ang_q >= min_q[out_ch_q] && out_ang_q <= max_q[out_ch_q])

endmodule

// ----- sv/joystick_servo_position_stepper_core.sv -----
// ----------------------------------------------------------------------------
// joystick_servo_position_stepper_core
// Gamepad report to servo target stepper with clamping and pulse counts.
// ----------------------------------------------------------------------------
// Each accepted report (left X, left Y, right Y, button byte) moves up to four
// servo targets and yields one result item per moved servo, in the order base,
// reach, lift, gripper; last_of_run_o marks the final item of a report, and a
// report that moves nothing yields no item. The front classifies a report in
// the cycle it is accepted and drops it into a two-entry command queue; the
// back pulls one servo per cycle from the queue head unless the output stalls,
// so a report with n moved servos (1 to 4) yields n result items; sustained
// throughput is one result item per cycle while out_ready_i is high.
// in_ready_o is high whenever the queue has room, so reports keep streaming in
// while results wait at the output register. Results pass the queue, then the
// output register. Limit registers take writes at any cycle (cfg_ready_o is
// tied high) and must be written only while no report is in flight.
// ----------------------------------------------------------------------------
module joystick_servo_position_stepper_core import jsps_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // report channel
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [15:0] left_x_i,
  input  logic [15:0] left_y_i,
  input  logic [15:0] right_y_i,
  input  logic [7:0]  button_bits_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  servo_channel_o,
  output logic [7:0]  servo_angle_o,
  output logic [9:0]  pulse_count_o,
  output logic        last_of_run_o,
  // limit register writes: index 2*servo is min, 2*servo+1 is max
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i
);

  logic push, full, pop, head_valid;
  cmd_t cmd, head;

  assign cfg_ready_o = 1'b1;

  // front: dead zone, step sign, button priority (L1 over R1)
  jsps_front u_front (
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .left_x_i      (left_x_i),
    .left_y_i      (left_y_i),
    .right_y_i     (right_y_i),
    .button_bits_i (button_bits_i),
    .full_i        (full),
    .push_o        (push),
    .cmd_o         (cmd)
  );

  // decouples report intake from result delivery
  jsps_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .cmd_i        (cmd),
    .full_o       (full),
    .pop_i        (pop),
    .head_o       (head),
    .head_valid_o (head_valid)
  );

  // back: target state, limits, clamping, pulse count, output register
  jsps_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .head_i          (head),
    .head_valid_i    (head_valid),
    .pop_o           (pop),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .servo_channel_o (servo_channel_o),
    .servo_angle_o   (servo_angle_o),
    .pulse_count_o   (pulse_count_o),
    .last_of_run_o   (last_of_run_o)
  );

endmodule

// ----- bench/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the joystick servo position stepper core.
// ----------------------------------------------------------------------------
// Gamepad reports go in on a valid/ready channel. Servo update items come back
// on a second valid/ready channel. A scoreboard class keeps its own copy of
// the four target angles and the eight limit registers. For every accepted
// report it works out the servo updates the core should emit and queues them.
// Each accepted update item is checked field by field against the oldest
// queued one. The sender works in bursts and the receiver stalls on a pattern
// of its own. One long receiver hold-off makes the core back up into its
// input. Limits are reprogrammed between phases, only once the core is empty.
// ----------------------------------------------------------------------------
module tb_top import jsps_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  // one expected servo update
  typedef struct packed {
    logic [1:0] chan;
    logic [7:0] angle;
    logic [9:0] pulse;
    logic       last_run;
  } servo_update_t;

  // --------------------------------------------------------------------------
  // scoreboard: predicts servo updates per report, checks them in order
  // --------------------------------------------------------------------------
  class servo_scoreboard;
    servo_update_t pending_q[$];
    int            lim_lo[4];
    int            lim_hi[4];
    int            target[4];
    int            errors;

    function new();
      lim_lo = '{20, 70, 45, 70};
      lim_hi = '{160, 110, 135, 110};
      target = '{90, 90, 90, 90};
      errors = 0;
    endfunction

    function void set_limit(logic [2:0] idx, logic [7:0] data);
      if (idx[0] == CfgLimMax) begin
        lim_hi[idx[2:1]] = data;
      end else begin
        lim_lo[idx[2:1]] = data;
      end
    endfunction

    // dead zone: far left of centre steps down, far right steps up, 1..8
    function int stick_step(logic [15:0] raw);
      int v;
      v = raw;
      if (v <= 'h7000) begin
        return -((32'h8000 - v) >> 12);
      end else if (v >= 'h8fff) begin
        return (v - 32'h7fff) >> 12;
      end
      return 0;
    endfunction

    // step one servo, min first then max, so max wins on crossed limits
    function void move(int ch, int step, ref servo_update_t run_q[$]);
      servo_update_t u;
      int a;
      a = target[ch] + step;
      if (a < lim_lo[ch]) a = lim_lo[ch];
      if (a > lim_hi[ch]) a = lim_hi[ch];
      target[ch] = a & 'hff;
      u.chan     = 2'(ch);
      u.angle    = 8'(target[ch]);
      u.pulse    = 10'((411 * target[ch]) / 180 + 101);
      u.last_run = 1'b0;
      run_q.push_back(u);
    endfunction

    function void note_report(logic [15:0] lx, logic [15:0] ly, logic [15:0] ry,
                              logic [7:0] btn);
      servo_update_t run_q[$];
      servo_update_t tail;
      int s;
      s = stick_step(lx);
      if (s != 0) move(ChBase, s, run_q);
      s = stick_step(ly);
      if (s != 0) move(ChReach, -s, run_q);
      s = stick_step(ry);
      if (s != 0) move(ChLift, -s, run_q);
      // L1 wins over R1
      if (btn[BtnClose]) begin
        move(ChGrip, -5, run_q);
      end else if (btn[BtnOpen]) begin
        move(ChGrip, 5, run_q);
      end
      if (run_q.size() > 0) begin
        tail = run_q.pop_back();
        tail.last_run = 1'b1;
        run_q.push_back(tail);
      end
      foreach (run_q[i]) pending_q.push_back(run_q[i]);
    endfunction

    function void fail(string what);
      if (errors < 10) $display("ERROR %0t: %s", $time, what);
      errors++;
    endfunction

    function void check_update(logic [1:0] ch, logic [7:0] ang, logic [9:0] pul,
                               logic lst);
      servo_update_t e;
      if (pending_q.size() == 0) begin
        fail($sformatf("unexpected item ch=%0d angle=%0d pulse=%0d last=%0b",
                       ch, ang, pul, lst));
        return;
      end
      e = pending_q.pop_front();
      if (ch !== e.chan || ang !== e.angle || pul !== e.pulse || lst !== e.last_run)
        fail($sformatf("exp ch=%0d angle=%0d pulse=%0d last=%0b, got ch=%0d angle=%0d pulse=%0d last=%0b",
                       e.chan, e.angle, e.pulse, e.last_run, ch, ang, pul, lst));
    endfunction

    function int pending();
      return pending_q.size();
    endfunction

    function void final_check();
      if (pending_q.size() != 0)
        fail($sformatf("%0d expected items never arrived", pending_q.size()));
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // signals, all inputs known from time zero
  // --------------------------------------------------------------------------
  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        in_valid_i    = 1'b0;
  logic        in_ready_o;
  logic [15:0] left_x_i      = 16'h8000;
  logic [15:0] left_y_i      = 16'h8000;
  logic [15:0] right_y_i     = 16'h8000;
  logic [7:0]  button_bits_i = 8'h00;
  logic        out_valid_o;
  logic        out_ready_i   = 1'b0;
  logic [1:0]  servo_channel_o;
  logic [7:0]  servo_angle_o;
  logic [9:0]  pulse_count_o;
  logic        last_of_run_o;
  logic        cfg_valid_i   = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i   = 3'd0;
  logic [7:0]  cfg_data_i    = 8'd0;

  servo_scoreboard servo_sb = new();

  int reports_sent = 0;
  bit hold_off     = 1'b0;   // long receiver hold-off request
  bit push_dir[4];           // per-axis drift direction of the random reports

  joystick_servo_position_stepper_core DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .left_x_i        (left_x_i),
    .left_y_i        (left_y_i),
    .right_y_i       (right_y_i),
    .button_bits_i   (button_bits_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .servo_channel_o (servo_channel_o),
    .servo_angle_o   (servo_angle_o),
    .pulse_count_o   (pulse_count_o),
    .last_of_run_o   (last_of_run_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  // 2 ns clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // receiver: stall pattern switches mode every so often; outside the hold-off, mode 0 never stalls
  // --------------------------------------------------------------------------
  int          stall_tick = 0;
  int unsigned stall_mode = 0;

  always @(posedge clk_i) begin
    stall_tick <= stall_tick + 1;
    if (stall_tick % 97 == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: out_ready_i <= !hold_off;
      1: out_ready_i <= !hold_off && ($urandom_range(0, 1) == 1);
      2: out_ready_i <= !hold_off && (stall_tick % 4 == 0);
      default: out_ready_i <= !hold_off && ($urandom_range(0, 7) != 0);
    endcase
  end

  // long hold-off once traffic is flowing: queue fills, in_ready_o must drop
  initial begin
    while (reports_sent < 40) @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (120) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  // monitor: sample on the edge, before the core updates its outputs
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      servo_sb.check_update(servo_channel_o, servo_angle_o, pulse_count_o, last_of_run_o);
  end

  // --------------------------------------------------------------------------
  // drivers
  // --------------------------------------------------------------------------
  // offer one report; valid stays up when gap is zero so bursts run back to back
  task automatic send_report(input logic [15:0] lx, input logic [15:0] ly,
                             input logic [15:0] ry, input logic [7:0] btn,
                             input int gap);
    in_valid_i    <= 1'b1;
    left_x_i      <= lx;
    left_y_i      <= ly;
    right_y_i     <= ry;
    button_bits_i <= btn;
    do @(posedge clk_i); while (!in_ready_o);
    servo_sb.note_report(lx, ly, ry, btn);
    reports_sent++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // all eight limit registers, min then max per servo; core must be idle
  task automatic program_limits(input int lo[4], input int hi[4]);
    logic [2:0] idx;
    logic [7:0] data;
    for (int w = 0; w < 8; w++) begin
      idx  = {2'(w / 2), (w % 2 == 1) ? CfgLimMax : ~CfgLimMax};
      data = (w % 2 == 1) ? 8'(hi[w / 2]) : 8'(lo[w / 2]);
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx;
      cfg_data_i  <= data;
      do @(posedge clk_i); while (!cfg_ready_o);
      servo_sb.set_limit(idx, data);
    end
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // wait for every expected item, then a margin for reports with no result
  task automatic drain();
    while (servo_sb.pending() > 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
  endtask

  // stick value: dead zone, anything, or pushed one way
  function automatic logic [15:0] pick_axis(input bit up);
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 3) return 16'($urandom_range(16'h7001, 16'h8ffe));
    if (r < 5) return 16'($urandom);
    return up ? 16'($urandom_range(16'h8fff, 16'hffff)) : 16'($urandom_range(0, 16'h7000));
  endfunction

  function automatic logic [7:0] pick_buttons(input bit open_dir);
    logic [7:0] b;
    b = 8'($urandom);
    if ($urandom_range(0, 3) != 0) begin
      b[BtnOpen]  = open_dir;
      b[BtnClose] = !open_dir;
    end
    return b;
  endfunction

  task automatic run_random(input int count);
    int left;
    int burst;
    int gap;
    left = count;
    while (left > 0) begin
      burst = $urandom_range(1, 12);
      if (burst > left) burst = left;
      for (int i = 0; i < burst; i++) begin
        for (int a = 0; a < 4; a++)
          if ($urandom_range(0, 15) == 0) push_dir[a] = !push_dir[a];
        gap = (i == burst - 1) ? $urandom_range(1, 10) : 0;
        send_report(pick_axis(push_dir[0]), pick_axis(push_dir[1]),
                    pick_axis(push_dir[2]), pick_buttons(push_dir[3]), gap);
      end
      left -= burst;
    end
  endtask

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    int lo[4];
    int hi[4];

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (3) @(posedge clk_i);

    // directed, reset limits
    send_report(16'h8000, 16'h8000, 16'h8000, 8'h00, 0);  // centred, nothing moves
    send_report(16'h0000, 16'h8000, 16'h8000, 8'h00, 0);  // base full left
    send_report(16'hffff, 16'h8000, 16'h8000, 8'h00, 1);  // base full right
    send_report(16'h7000, 16'h8000, 16'h8000, 8'h00, 0);  // dead zone lower edge, -1
    send_report(16'h7001, 16'h8ffe, 16'h8000, 8'h00, 0);  // just inside dead zone
    send_report(16'h8fff, 16'h8000, 16'h8000, 8'h00, 2);  // dead zone upper edge, +1
    send_report(16'h8000, 16'h0000, 16'h8000, 8'h00, 0);  // reach, negated Y
    send_report(16'h8000, 16'hffff, 16'h8000, 8'h00, 0);
    send_report(16'h8000, 16'h8000, 16'h0000, 8'h00, 0);  // lift
    send_report(16'h8000, 16'h8000, 16'hffff, 8'h00, 1);
    send_report(16'h8000, 16'h8000, 16'h8000, 8'h40, 0);  // L1 closes
    send_report(16'h8000, 16'h8000, 16'h8000, 8'h80, 0);  // R1 opens
    send_report(16'h8000, 16'h8000, 16'h8000, 8'hc0, 0);  // both bumpers, L1 wins
    send_report(16'h8000, 16'h8000, 16'h8000, 8'h3f, 1);  // other buttons only
    // all four servos at once, repeated until every target sits on a limit
    for (int i = 0; i < 9; i++)
      send_report(16'hffff, 16'h0000, 16'hffff, 8'h80, (i == 8) ? 3 : 0);
    drain();

    run_random(70);
    drain();

    // widest limits, angles may reach 255
    lo = '{0, 0, 0, 0};
    hi = '{255, 255, 255, 255};
    program_limits(lo, hi);
    push_dir = '{1, 0, 1, 1};
    run_random(40);
    push_dir = '{0, 1, 0, 0};
    run_random(30);
    drain();

    // crossed limits, the maximum wins; one equal pair
    lo = '{200, 255, 180, 90};
    hi = '{10, 0, 179, 90};
    program_limits(lo, hi);
    run_random(50);
    drain();

    // random limit settings
    for (int p = 0; p < 3; p++) begin
      foreach (lo[s]) begin
        lo[s] = $urandom_range(0, 255);
        hi[s] = $urandom_range(0, 255);
      end
      program_limits(lo, hi);
      run_random(30);
      drain();
    end

    servo_sb.final_check();
    if (servo_sb.errors == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("tb_top NOT OK");
    $finish;
  end

endmodule
